// ===== sv/cual_pkg.sv =====
// ----------------------------------------------------------------------------
// cual_pkg
// Shared types and constants of the card UID allow list: payload structs,
// action and status codes, slot table sizing and the store control bundle.
// ----------------------------------------------------------------------------
package cual_pkg;

  localparam int SLOT_COUNT   = 64;
  localparam int SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int SLOT_CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_FIELD_W = 6;

  localparam int UID_LOW_W  = 64;
  localparam int UID_HIGH_W = 16;
  localparam int UID_LEN_W  = 4;
  localparam int KEY_W      = UID_LOW_W + UID_HIGH_W + UID_LEN_W;
  localparam logic [UID_LEN_W-1:0] UID_MAX_LEN = 4'd10;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_BIT = 2;
  localparam logic REG_READER_ENABLED = 1'b0;

  localparam logic [1:0] ACT_CHECK  = 2'd0;
  localparam logic [1:0] ACT_ENROLL = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]            action;
    logic [UID_LOW_W-1:0]  uid_low;
    logic [UID_HIGH_W-1:0] uid_high;
    logic [UID_LEN_W-1:0]  uid_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              table_status;
    logic [SLOT_FIELD_W-1:0] slot_used;
    logic                    authorized;
    logic                    unlock;
  } out_item_t;

  typedef struct packed {
    logic                  rd_en;
    logic [SLOT_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0]      wr_data;
    logic                  clr_en;
    logic [SLOT_IDX_W-1:0] clr_addr;
  } store_ctl_t;

  typedef struct packed {
    logic             rd_valid;
    logic [KEY_W-1:0] rd_data;
  } store_rsp_t;

endpackage

// ===== sv/cual_slot_store.sv =====
// ----------------------------------------------------------------------------
// cual_slot_store
// Slot table: a UID memory with one write port and one read port, registered
// read data, plus one valid flip-flop per slot that reset clears.
// ----------------------------------------------------------------------------
module cual_slot_store (
  input  logic                clk,
  input  logic                rst_n,
  input  cual_pkg::store_ctl_t ctl,
  output cual_pkg::store_rsp_t rsp
);
  import cual_pkg::*;

  logic [KEY_W-1:0]      mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [KEY_W-1:0]      rd_data_r;
  logic                  rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.clr_en) begin
        valid_r[ctl.clr_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[ctl.rd_addr];
      end
    end
  end

  assign rsp.rd_valid = rd_valid_r;
  assign rsp.rd_data  = rd_data_r;

endmodule

// ===== sv/card_uid_allow_list.sv =====
// ----------------------------------------------------------------------------
// card_uid_allow_list
// Allow list of card UIDs: check, enroll or remove a scanned UID and report
// whether the card may unlock.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer happens at a clock edge with start high and busy low;
//   in_item carries the action, the UID bytes and the UID length. Bytes at or
//   beyond the length are taken as zero and lengths above ten as ten.
//   Each command yields one result on out_item, shown for exactly one cycle
//   with out_valid high. The receiver cannot hold it off.
//   Timing: one sweep of a single compare unit over the slot memory, one slot
//   read per cycle through the memory's read port. A result appears after the
//   sweep and the table operation, and busy drops in that same cycle, so a
//   new command is taken only once the result of the last one is out.
//   The APB port holds reader_enabled at address 0 (and its aliases 1 to 3,
//   where paddr bit 2 is clear); pready is always high. Reset clears every
//   slot valid bit, sets reader_enabled and leaves the block idle. Slot
//   contents are not cleared; they are read only through a set valid bit.
// ----------------------------------------------------------------------------
module card_uid_allow_list (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cual_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  output cual_pkg::out_item_t                 out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cual_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [cual_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [cual_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import cual_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [1:0]            action_r, action_nxt;
  logic [SLOT_CNT_W-1:0] iss_r, iss_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                  match_found_r, match_found_nxt;
  logic [SLOT_IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [SLOT_IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;
  logic                  reader_enabled_r;
  logic                  hit;
  store_ctl_t            ctl;
  store_rsp_t            rsp;

  // Builds the stored form of a UID: length, then masked bytes 8..9 and 0..7.
  function automatic logic [KEY_W-1:0] make_key(input in_item_t item);
    logic [UID_LEN_W-1:0]  len;
    logic [UID_LOW_W-1:0]  lo;
    logic [UID_HIGH_W-1:0] hi;
    len = (item.uid_length > UID_MAX_LEN) ? UID_MAX_LEN : item.uid_length;
    lo  = item.uid_low;
    hi  = item.uid_high;
    for (int b = 0; b < 8; b++) begin
      if (UID_LEN_W'(b) >= len) begin
        lo[8*b +: 8] = 8'd0;
      end
    end
    for (int b = 0; b < 2; b++) begin
      if (UID_LEN_W'(b + 8) >= len) begin
        hi[8*b +: 8] = 8'd0;
      end
    end
    return {len, hi, lo};
  endfunction

  cual_slot_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .rsp   (rsp)
  );

  assign hit = rsp.rd_valid && (rsp.rd_data == key_r);

  always_comb begin
    state_nxt       = state_r;
    key_nxt         = key_r;
    action_nxt      = action_r;
    iss_nxt         = iss_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = cmp_idx_r;
    match_found_nxt = match_found_r;
    match_idx_nxt   = match_idx_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    ctl             = '0;
    ctl.wr_data     = key_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          key_nxt         = make_key(in_item);
          action_nxt      = in_item.action;
          iss_nxt         = '0;
          match_found_nxt = 1'b0;
          free_found_nxt  = 1'b0;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        // Each read is issued in the cycle before the compare that uses its data.
        if (iss_r < SLOT_CNT_W'(SLOT_COUNT)) begin
          ctl.rd_en   = 1'b1;
          ctl.rd_addr = iss_r[SLOT_IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[SLOT_IDX_W-1:0];
        end
        if (cmp_vld_r) begin
          if (hit && !match_found_r) begin
            match_found_nxt = 1'b1;
            match_idx_nxt   = cmp_idx_r;
          end
          if (!rsp.rd_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (cmp_idx_r == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        // Enroll never creates a duplicate, so a removed UID is no longer
        // present and the lookup after the table operation needs no sweep.
        out_item_nxt = '0;
        case (action_r)
          ACT_ENROLL: begin
            if (match_found_r) begin
              out_item_nxt.table_status = ST_PRESENT;
              out_item_nxt.slot_used    = SLOT_FIELD_W'(match_idx_r);
              out_item_nxt.authorized   = 1'b1;
            end else if (free_found_r) begin
              out_item_nxt.table_status = ST_ADDED;
              out_item_nxt.slot_used    = SLOT_FIELD_W'(free_idx_r);
              out_item_nxt.authorized   = 1'b1;
              ctl.wr_en                 = 1'b1;
              ctl.wr_addr               = free_idx_r;
            end else begin
              out_item_nxt.table_status = ST_FULL;
            end
          end
          ACT_REMOVE: begin
            if (match_found_r) begin
              out_item_nxt.table_status = ST_REMOVED;
              out_item_nxt.slot_used    = SLOT_FIELD_W'(match_idx_r);
              ctl.clr_en                = 1'b1;
              ctl.clr_addr              = match_idx_r;
            end else begin
              out_item_nxt.table_status = ST_NOT_FOUND;
            end
          end
          default: begin
            out_item_nxt.table_status = ST_NONE;
            if (match_found_r) begin
              out_item_nxt.slot_used  = SLOT_FIELD_W'(match_idx_r);
              out_item_nxt.authorized = 1'b1;
            end
          end
        endcase
        out_item_nxt.unlock = out_item_nxt.authorized && reader_enabled_r;
        out_valid_nxt       = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    action_r      <= action_nxt;
    iss_r         <= iss_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    match_found_r <= match_found_nxt;
    match_idx_r   <= match_idx_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    out_item_r    <= out_item_nxt;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reader_enabled_r <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[CFG_IDX_BIT] == REG_READER_ENABLED)) begin
      reader_enabled_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[CFG_IDX_BIT] == REG_READER_ENABLED) ?
                  CFG_DATA_W'(reader_enabled_r) : '0;
  assign pready    = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command transfer did not make the block busy");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FINISH))
    else $error("result strobe without a finished sweep");

  a_added_auth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.table_status == ST_ADDED)) |-> out_item.authorized)
    else $error("added UID not reported as authorized");

  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= SLOT_CNT_W'(SLOT_COUNT)))
    else $error("read issue counter ran past the table");
`endif

endmodule

// ===== bench/card_uid_allow_list_checker.sv =====
// ----------------------------------------------------------------------------
// card_uid_allow_list_checker
// Watches the command, result and APB channels of the allow list. It keeps its
// own slot table and enable bit, predicts one result per accepted command and
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module card_uid_allow_list_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  cual_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  cual_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [cual_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cual_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [cual_pkg::CFG_DATA_W-1:0] prdata,
  output int                              mismatches,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cual_pkg::*;

  logic             slot_live [SLOT_COUNT];
  logic [KEY_W-1:0] slot_key  [SLOT_COUNT];
  logic             unlock_en;
  out_item_t        expected_results [$];

  // The key is the UID with bytes past its length zeroed, then the length.
  function automatic logic [KEY_W-1:0] card_key(input in_item_t it);
    logic [UID_LEN_W-1:0]  n;
    logic [UID_LOW_W-1:0]  lo;
    logic [UID_HIGH_W-1:0] hi;
    n  = (it.uid_length > UID_MAX_LEN) ? UID_MAX_LEN : it.uid_length;
    lo = it.uid_low;
    hi = it.uid_high;
    for (int b = 0; b < 8; b++)
      if (b >= n) lo[8*b +: 8] = 8'h00;
    for (int b = 0; b < 2; b++)
      if (b + 8 >= n) hi[8*b +: 8] = 8'h00;
    return {lo, hi, n};
  endfunction

  function automatic int find_card(input logic [KEY_W-1:0] key);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_live[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  task automatic apply_scan(input in_item_t it, output out_item_t res);
    logic [KEY_W-1:0] key;
    logic [2:0]       status;
    int               hit;
    int               slot;
    key    = card_key(it);
    status = ST_NONE;
    slot   = 0;
    case (it.action)
      ACT_ENROLL: begin
        hit = find_card(key);
        if (hit >= 0) begin
          status = ST_PRESENT;
          slot   = hit;
        end else begin
          status = ST_FULL;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_live[i]) begin
              slot_live[i] = 1'b1;
              slot_key[i]  = key;
              status       = ST_ADDED;
              slot         = i;
              break;
            end
          end
        end
      end
      ACT_REMOVE: begin
        hit = find_card(key);
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          status         = ST_REMOVED;
          slot           = hit;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    hit = find_card(key);
    if (status == ST_NONE && hit >= 0) slot = hit;
    res.table_status = status;
    res.slot_used    = SLOT_FIELD_W'(slot);
    res.authorized   = (hit >= 0);
    res.unlock       = (hit >= 0) && unlock_en;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t pred;
    if (!rst_n) begin
      mismatches = 0;
      unlock_en  = 1'b1;
      for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, out_item);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("table_status", 8'(want.table_status), 8'(out_item.table_status));
          check_field("slot_used", 8'(want.slot_used), 8'(out_item.slot_used));
          check_field("authorized", 8'(want.authorized), 8'(out_item.authorized));
          check_field("unlock", 8'(want.unlock), 8'(out_item.unlock));
        end
      end
      if (start && !busy) begin
        apply_scan(in_item, pred);
        expected_results.push_back(pred);
      end
      if (psel && penable && pready &&
          paddr[CFG_ADDR_W-1:CFG_IDX_BIT] == REG_READER_ENABLED) begin
        if (pwrite) begin
          unlock_en = pwdata[0];
        end else if (prdata !== CFG_DATA_W'(unlock_en)) begin
          $display("%0t: reader_enabled read expected %0d, got %0d",
                   $time, unlock_en, prdata);
          mismatches++;
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== bench/card_uid_allow_list_tb.sv =====
// ----------------------------------------------------------------------------
// card_uid_allow_list_tb
// Drives scan commands and reader_enabled writes into the allow list and
// gives the verdict. A directed part covers the edge cases of UID length,
// masking and table operations; a random part draws UIDs from a pool so that
// enrolls, removes and a full table are all reached. Checking is done by the
// checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module card_uid_allow_list_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cual_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // undefined action, handled as a check
  localparam logic [CFG_ADDR_W-1:0] ENABLE_ADDR =
    CFG_ADDR_W'(REG_READER_ENABLED) << CFG_IDX_BIT;
  localparam int POOL_SIZE    = 100;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                  clk     = 1'b0;
  logic                  rst_n   = 1'b0;
  logic                  start   = 1'b0;
  in_item_t              in_item = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic                  busy;
  logic                  out_valid;
  out_item_t             out_item;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    outstanding;
  int                    cycles = 0;

  logic [79:0]          pool_key [POOL_SIZE];
  logic [UID_LEN_W-1:0] pool_len [POOL_SIZE];

  card_uid_allow_list dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  card_uid_allow_list_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
    .mismatches, .outstanding
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("card_uid_allow_list_tb failed");
      $finish;
    end
  end

  function automatic in_item_t scan(input logic [1:0] action, input logic [63:0] lo,
                                    input logic [15:0] hi, input logic [3:0] len);
    in_item_t it;
    it.action     = action;
    it.uid_low    = lo;
    it.uid_high   = hi;
    it.uid_length = len;
    return it;
  endfunction

  // Byte mask of the bytes that a UID of length n really uses.
  function automatic logic [79:0] used_bytes(input logic [3:0] n);
    logic [79:0] m;
    m = '0;
    for (int b = 0; b < 10; b++)
      if (b < n) m[8*b +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic logic [79:0] rand80();
    return {16'($urandom_range(16'hFFFF)), $urandom, $urandom};
  endfunction

  // Mode 0 fills the table, mode 1 empties it, mode 2 is balanced.
  function automatic in_item_t make_scan(input int mode);
    in_item_t    it;
    int          k;
    int          pick;
    int          enroll_pct;
    int          remove_pct;
    logic [79:0] m;
    logic [79:0] raw;
    if ($urandom_range(99) < 8) begin
      raw = rand80();
      return scan(2'($urandom_range(3)), raw[63:0], raw[79:64],
                  4'($urandom_range(15)));
    end
    k   = $urandom_range(POOL_SIZE - 1);
    m   = used_bytes(pool_len[k]);
    raw = (pool_key[k] & m) | (rand80() & ~m);
    it  = scan(ACT_CHECK, raw[63:0], raw[79:64], pool_len[k]);
    if (pool_len[k] == UID_MAX_LEN && $urandom_range(3) == 0)
      it.uid_length = 4'($urandom_range(10, 15));
    enroll_pct = (mode == 0) ? 55 : (mode == 1) ? 10 : 30;
    remove_pct = (mode == 0) ? 10 : (mode == 1) ? 55 : 30;
    pick = $urandom_range(99);
    if (pick < 5)                            it.action = ACT_SPARE;
    else if (pick < 5 + enroll_pct)          it.action = ACT_ENROLL;
    else if (pick < 5 + enroll_pct + remove_pct) it.action = ACT_REMOVE;
    return it;
  endfunction

  // A write of reader_enabled followed by a read back; noise in the upper bits.
  task automatic set_reader(input logic en);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= ($urandom & ~32'h1) | CFG_DATA_W'(en);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds start until the transfer is taken. When the previous command went
  // through at this same edge and no gap is chosen, start simply stays high.
  task automatic feed(input in_item_t it, input bit may_idle);
    if (may_idle && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [79:0] ones;
    logic [79:0] u;
    ones = '1;
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_len[k] = 4'($urandom_range(10));
      pool_key[k] = rand80() & used_bytes(pool_len[k]);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_reader(1'b1);

    u = rand80();
    feed(scan(ACT_CHECK,  ones[63:0], ones[79:64], 4'd10), 1'b1);
    feed(scan(ACT_ENROLL, ones[63:0], ones[79:64], 4'd10), 1'b1);
    feed(scan(ACT_CHECK,  ones[63:0], ones[79:64], 4'd10), 1'b1);
    feed(scan(ACT_ENROLL, ones[63:0], ones[79:64], 4'd15), 1'b1);
    // Zero length: a UID with no bytes at all, whatever the byte fields hold.
    feed(scan(ACT_ENROLL, u[63:0], u[79:64], 4'd0), 1'b1);
    feed(scan(ACT_CHECK,  64'h0, 16'h0, 4'd0), 1'b1);
    feed(scan(ACT_ENROLL, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF, 4'd1), 1'b1);
    feed(scan(ACT_ENROLL, ones[63:0], 16'hA5C3, 4'd8), 1'b1);
    feed(scan(ACT_ENROLL, 64'h0, 16'hFF5A, 4'd9), 1'b1);
    feed(scan(ACT_SPARE,  64'h0, 16'h005A, 4'd9), 1'b1);
    feed(scan(ACT_REMOVE, 64'h0, 16'h0, 4'd0), 1'b1);
    feed(scan(ACT_REMOVE, 64'h0, 16'h0, 4'd0), 1'b1);
    feed(scan(ACT_CHECK,  64'h0, 16'h0, 4'd0), 1'b1);
    feed(scan(ACT_ENROLL, u[63:0], u[79:64], 4'd5), 1'b1);
    feed(scan(ACT_REMOVE, ones[63:0], ones[79:64], 4'd12), 1'b1);
    feed(scan(ACT_ENROLL, 64'h0, 16'h0, 4'd2), 1'b1);
    drain();
    set_reader(1'b0);
    feed(scan(ACT_CHECK,  ones[63:0], 16'h0, 4'd8), 1'b1);
    feed(scan(ACT_SPARE,  64'h0, 16'h005A, 4'd9), 1'b1);
    feed(scan(ACT_ENROLL, u[63:0], u[79:64], 4'd7), 1'b1);
    feed(scan(ACT_REMOVE, ~u[63:0], u[79:64], 4'd10), 1'b1);
    drain();
    set_reader(1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0 && n != 0) begin
        drain();
        set_reader((n / 250) % 3 != 1);
      end
      feed(make_scan((n / 150) % 3), !(n >= 900 && n < 1300));
    end

    drain();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("card_uid_allow_list_tb passed");
    end else begin
      $display("card_uid_allow_list_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cual_pkg.sv
sv/cual_slot_store.sv
sv/card_uid_allow_list.sv
bench/card_uid_allow_list_checker.sv
bench/card_uid_allow_list_tb.sv
